[rtl/core/pbpm_pkg.sv]
// Shared types, sizes and operation codes of the packet buffer pool manager.
package pbpm_pkg;

   localparam int POOL_BUFFERS = 32;
   localparam int BUFFER_BYTES = 2048;

   localparam int IDX_W     = (POOL_BUFFERS > 1) ? $clog2(POOL_BUFFERS) : 1;
   localparam int LEN_W     = $clog2(BUFFER_BYTES + 1);
   localparam int MEM_DEPTH = POOL_BUFFERS * BUFFER_BYTES;
   localparam int MEM_AW    = $clog2(MEM_DEPTH);

   localparam logic [2:0] OP_ALLOC   = 3'd0;
   localparam logic [2:0] OP_FREE    = 3'd1;
   localparam logic [2:0] OP_REWIND  = 3'd2;
   localparam logic [2:0] OP_ADVANCE = 3'd3;
   localparam logic [2:0] OP_WRITE   = 3'd4;
   localparam logic [2:0] OP_PEEK    = 3'd5;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NO_FREE = 2'd1;
   localparam logic [1:0] ST_REFUSED = 2'd2;

   typedef struct packed {
      logic [2:0]  op;
      logic [4:0]  buffer_index;
      logic [11:0] amount;
      logic [7:0]  data_byte;
      logic        first_of_write;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [4:0]  given_index;
      logic [11:0] remaining;
      logic [7:0]  read_byte;
   } rsp_type;

   typedef struct packed {
      logic              wr_en;
      logic              rd_en;
      logic [MEM_AW-1:0] addr;
      logic [7:0]        wr_data;
   } mem_ctrl_type;

endpackage

[rtl/core/pbpm_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
module pbpm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/pbpm_table.sv]
// Per-buffer state table: used marks, fill lengths, read offsets and the operation logic.
module pbpm_table (
   input  logic                  clock,
   input  logic                  reset,
   input  pbpm_pkg::req_type     item,
   input  logic                  commit,
   output pbpm_pkg::rsp_type     result,
   output logic                  peek_hit,
   output pbpm_pkg::mem_ctrl_type mem
);

   localparam int IDX_W  = pbpm_pkg::IDX_W;
   localparam int LEN_W  = pbpm_pkg::LEN_W;
   localparam int MEM_AW = pbpm_pkg::MEM_AW;
   localparam int POOL   = pbpm_pkg::POOL_BUFFERS;
   localparam int BYTES  = pbpm_pkg::BUFFER_BYTES;

   logic [POOL-1:0]  in_use_ff;
   logic [LEN_W-1:0] fill_ff [POOL];
   logic [LEN_W-1:0] off_ff  [POOL];
   logic             refused_ff;
   logic             refused_in;

   logic [31:0]      idx_wide;
   logic             in_range;
   logic [IDX_W-1:0] bidx;
   logic [31:0]      amt_wide;
   logic [LEN_W-1:0] amt;
   logic [LEN_W-1:0] fill_cur;
   logic [LEN_W-1:0] off_cur;
   logic             use_cur;
   logic             found;
   logic [IDX_W-1:0] free_idx;
   logic [LEN_W:0]   fit_sum;
   logic             fit_fail;
   logic [LEN_W:0]   adv_sum;
   logic [LEN_W-1:0] off_adv;
   logic [LEN_W-1:0] fill_new;
   logic [LEN_W-1:0] off_new;
   logic             use_new;
   logic             refuse_now;
   logic [LEN_W-1:0] rem;
   logic [MEM_AW-1:0] base;
   logic             is_alloc;

   assign idx_wide = 32'(item.buffer_index);
   assign in_range = idx_wide < 32'(POOL);
   assign bidx     = idx_wide[IDX_W-1:0];
   assign is_alloc = item.op == pbpm_pkg::OP_ALLOC;

   assign amt_wide = 32'(item.amount);
   assign amt      = (amt_wide > 32'(BYTES)) ? LEN_W'(BYTES) : amt_wide[LEN_W-1:0];

   assign fill_cur = in_range ? fill_ff[bidx] : '0;
   assign off_cur  = in_range ? off_ff[bidx] : '0;
   assign use_cur  = in_range ? in_use_ff[bidx] : 1'b0;

   // Lowest free buffer; the loop runs downward so the lowest index wins.
   always_comb begin
      found    = 1'b0;
      free_idx = '0;
      for (int i = POOL - 1; i >= 0; i--) begin
         if (!in_use_ff[i]) begin
            found    = 1'b1;
            free_idx = IDX_W'(i);
         end
      end
   end

   assign fit_sum  = {1'b0, fill_cur} + {1'b0, amt};
   assign fit_fail = fit_sum > (LEN_W + 1)'(BYTES);
   assign adv_sum  = {1'b0, off_cur} + {1'b0, amt};
   assign off_adv  = (adv_sum > {1'b0, fill_cur}) ? fill_cur : adv_sum[LEN_W-1:0];

   assign base = MEM_AW'(bidx) * MEM_AW'(BYTES);

   always_comb begin
      fill_new       = fill_cur;
      off_new        = off_cur;
      use_new        = use_cur;
      refused_in     = refused_ff;
      refuse_now     = 1'b0;
      peek_hit       = 1'b0;
      rem            = '0;
      mem.wr_en      = 1'b0;
      mem.wr_data    = item.data_byte;
      mem.addr       = base + MEM_AW'(off_cur);
      result.status      = pbpm_pkg::ST_OK;
      result.given_index = '0;
      result.remaining   = '0;
      result.read_byte   = '0;
      if (is_alloc) begin
         if (found) begin
            result.given_index = 5'(32'(free_idx));
         end else begin
            result.status = pbpm_pkg::ST_NO_FREE;
         end
      end else if (in_range) begin
         case (item.op)
            pbpm_pkg::OP_FREE: begin
               use_new = 1'b0;
            end
            pbpm_pkg::OP_REWIND: begin
               off_new = '0;
            end
            pbpm_pkg::OP_ADVANCE: begin
               off_new = off_adv;
            end
            pbpm_pkg::OP_WRITE: begin
               // The fit check on the first byte decides the fate of the whole write.
               refuse_now = item.first_of_write ? fit_fail : refused_ff;
               refused_in = refuse_now;
               if (refuse_now) begin
                  result.status = pbpm_pkg::ST_REFUSED;
               end else if (amt != '0 && fill_cur < LEN_W'(BYTES)) begin
                  mem.wr_en = 1'b1;
                  mem.addr  = base + MEM_AW'(fill_cur);
                  fill_new  = fill_cur + LEN_W'(1);
               end
            end
            pbpm_pkg::OP_PEEK: begin
               peek_hit = (off_cur < fill_cur) && (off_cur < LEN_W'(BYTES));
            end
            default: begin
            end
         endcase
         rem = (off_new > fill_new) ? '0 : fill_new - off_new;
         result.remaining = 12'(rem);
      end
      mem.rd_en = commit && peek_hit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_use_ff  <= '0;
         refused_ff <= 1'b0;
         for (int i = 0; i < POOL; i++) begin
            fill_ff[i] <= '0;
            off_ff[i]  <= '0;
         end
      end else if (commit) begin
         if (is_alloc) begin
            if (found) begin
               in_use_ff[free_idx] <= 1'b1;
               fill_ff[free_idx]   <= '0;
               off_ff[free_idx]    <= '0;
            end
         end else if (in_range) begin
            in_use_ff[bidx] <= use_new;
            fill_ff[bidx]   <= fill_new;
            off_ff[bidx]    <= off_new;
            refused_ff      <= refused_in;
         end
      end
   end

endmodule

[rtl/core/packet_buffer_pool_manager.sv]
// Top level of the packet buffer pool manager: input register, state table, byte RAM, result register.
//
// One operation is taken per clock cycle, unless the input register holds an item that cannot
// yet move on. An accepted item sits in the input register; from there the per-buffer table is
// read, updated and written back and the byte RAM is written or read, and the result register
// loads as the item leaves the input register, so the result is offered from then on. The result
// register (with the RAM's registered read data for a peek) holds the answer until the receiver
// takes it. The first free buffer on an allocate comes from a priority encoder over the used
// marks. An input item is still accepted while a finished result waits, as long as the input
// register is free. The byte store comes up unwritten; a peek only ever reads bytes below the
// buffer's fill length, which an allocate clears to zero.
module packet_buffer_pool_manager (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  pbpm_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output pbpm_pkg::rsp_type rsp_data
);

   logic                   s1_vld_ff;
   logic                   s1_vld_in;
   pbpm_pkg::req_type      s1_ff;
   logic                   out_vld_ff;
   logic                   out_vld_in;
   pbpm_pkg::rsp_type      out_ff;
   logic                   hit_ff;
   logic                   advance;
   logic                   accept;
   pbpm_pkg::rsp_type      result;
   logic                   peek_hit;
   pbpm_pkg::mem_ctrl_type mem;
   logic [7:0]             ram_q;

   assign advance   = s1_vld_ff && (!out_vld_ff || !rsp_stall);
   assign req_stall = s1_vld_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      s1_vld_in = s1_vld_ff;
      if (accept) begin
         s1_vld_in = 1'b1;
      end else if (advance) begin
         s1_vld_in = 1'b0;
      end
      out_vld_in = out_vld_ff;
      if (advance) begin
         out_vld_in = 1'b1;
      end else if (out_vld_ff && !rsp_stall) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= req_data;
      end
      if (advance) begin
         out_ff <= result;
         hit_ff <= peek_hit;
      end
   end

   pbpm_table u_table (
      .clock    (clock),
      .reset    (reset),
      .item     (s1_ff),
      .commit   (advance),
      .result   (result),
      .peek_hit (peek_hit),
      .mem      (mem)
   );

   // The read port only loads on a committed peek, so its data holds while the result stalls.
   pbpm_ram #(
      .WIDTH (8),
      .DEPTH (pbpm_pkg::MEM_DEPTH)
   ) u_bytes (
      .clock   (clock),
      .wr_en   (mem.wr_en && advance),
      .wr_addr (mem.addr),
      .wr_data (mem.wr_data),
      .rd_en   (mem.rd_en),
      .rd_addr (mem.addr),
      .rd_data (ram_q)
   );

   assign rsp_valid = out_vld_ff;

   always_comb begin
      rsp_data           = out_ff;
      rsp_data.read_byte = hit_ff ? ram_q : 8'd0;
   end

endmodule
